FILE: sv/frs6_pkg.sv
package frs6_pkg;

    // Filter geometry and number formats
    localparam int TAPS        = 101;
    localparam int HALF_TAPS   = (TAPS + 1) / 2;
    localparam int FACTOR      = 6;
    localparam int SAMPLE_BITS = 16;
    localparam int TAP_BITS    = 18;
    localparam int GAIN_BITS   = 16;
    localparam int ADDR_W      = $clog2(TAPS);
    localparam int STEP_W      = $clog2(FACTOR);
    localparam int PROD_BITS   = TAP_BITS + SAMPLE_BITS;
    localparam int ACC_BITS    = PROD_BITS + 2;
    localparam int SCALED_BITS = ACC_BITS + GAIN_BITS + 1;
    localparam int ROUND_SHIFT = 29;
    localparam int SHIFTED_BITS = SCALED_BITS - ROUND_SHIFT;

    // Register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_UP_GAIN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_GAIN = 1'd1;
    localparam logic [GAIN_BITS-1:0] UP_GAIN_RESET   = 16'd24576;
    localparam logic [GAIN_BITS-1:0] DOWN_GAIN_RESET = 16'd3686;

    // Operation codes
    localparam logic [1:0] FUNC_INTERP = 2'd0;
    localparam logic [1:0] FUNC_DECIM  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_MAC,
        S_DRAIN,
        S_OUT
    } state_t;

    // First half of the symmetric tap set, center tap last, Q1.17
    localparam logic signed [TAP_BITS-1:0] HALF_TAP [HALF_TAPS] = '{
        -18'sd31,   18'sd18,    -18'sd77,   -18'sd310,  -18'sd650,
        -18'sd1047, -18'sd1440, -18'sd1762, -18'sd1960, -18'sd1996,
        -18'sd1860, -18'sd1571, -18'sd1174, -18'sd736,  -18'sd335,
        -18'sd46,   18'sd71,    -18'sd18,   -18'sd314,  -18'sd782,
        -18'sd1355, -18'sd1943, -18'sd2449, -18'sd2780, -18'sd2870,
        -18'sd2685, -18'sd2240, -18'sd1590, -18'sd836,  -18'sd100,
        18'sd485,   18'sd799,   18'sd756,   18'sd319,   -18'sd484,
        -18'sd1564, -18'sd2773, -18'sd3922, -18'sd4806, -18'sd5226,
        -18'sd5024, -18'sd4103, -18'sd2448, -18'sd130,  18'sd2691,
        18'sd5787,  18'sd8880,  18'sd11679, 18'sd13907, 18'sd15343,
        18'sd15838
    };

    // Coefficient for tap k, folding the upper half onto the lower half
    function automatic logic signed [TAP_BITS-1:0] tap_coef(input logic [ADDR_W-1:0] k);
        logic [ADDR_W-1:0] mirror;
        logic [ADDR_W-1:0] m;
        mirror = ADDR_W'(TAPS - 1) - k;
        m = (k < mirror) ? k : mirror;
        return HALF_TAP[m[$clog2(HALF_TAPS)-1:0]];
    endfunction

endpackage

FILE: sv/fir_resampler_by_six.sv
// Shared 101-tap low-pass FIR for 8 kHz <-> 48 kHz conversion. An interpolate beat
// (func 0) writes the sample and then five zeros into the delay line and returns six
// results scaled by up_gain, the last flagged by m_last_of_run. A decimate beat
// (func 1) writes the sample; only the first of each group of six returns a result,
// scaled by down_gain. A clear beat (func 2) empties the history and restarts the
// group; func 3 does nothing. The delay line sits in a single-port-read memory and
// one multiply-accumulate walks it one tap per cycle. Each filter pass writes the
// delay line, walks all 101 taps, drains and scales the sum, then hands the result
// to the output register. The block takes a new beat once the previous one is done,
// even while its last result still waits in the output register. Gains are written
// over cfg_we/cfg_index/cfg_wdata; the user must write them only while the block is
// idle, which the block itself does not enforce.
module fir_resampler_by_six (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [frs6_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [frs6_pkg::GAIN_BITS-1:0]       cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_func,
    input  logic signed [frs6_pkg::SAMPLE_BITS-1:0] s_in_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [frs6_pkg::SAMPLE_BITS-1:0] m_out_sample,
    output logic                                 m_last_of_run
);
    import frs6_pkg::*;

    localparam logic signed [SHIFTED_BITS-1:0] SAT_MAX =
        SHIFTED_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SHIFTED_BITS-1:0] SAT_MIN =
        SHIFTED_BITS'(-(1 << (SAMPLE_BITS - 1)));
    localparam logic signed [SCALED_BITS-1:0] ROUND_HALF =
        SCALED_BITS'(1) <<< (ROUND_SHIFT - 1);

    state_t state_reg, state_next;

    logic [GAIN_BITS-1:0]          up_gain_reg, down_gain_reg;
    logic [1:0]                    func_reg, func_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [ADDR_W-1:0]             wp_reg, wp_next;
    logic [STEP_W-1:0]             phase_reg, phase_next;
    logic [TAPS-1:0]               vld_reg, vld_next;
    logic [ADDR_W-1:0]             rd_addr_reg, rd_addr_next;
    logic [ADDR_W-1:0]             k_reg, k_next;
    logic signed [TAP_BITS-1:0]    tap_q_reg, tap_q_next;
    logic                          st1_v_reg, st1_v_next;
    logic                          st2_v_reg, st2_v_next;
    logic signed [PROD_BITS-1:0]   prod_reg, prod_next;
    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;
    logic signed [SCALED_BITS-1:0] scaled_reg, scaled_next;
    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic                          last_reg, last_next;

    logic                          mem_we;
    logic signed [SAMPLE_BITS-1:0] mem_wdata;
    logic signed [SAMPLE_BITS-1:0] hist_mem [TAPS];
    logic signed [SAMPLE_BITS-1:0] rdata_reg;
    logic                          rvld_reg;

    logic                          s_fire;
    logic                          out_free;
    logic                          last_pass;
    logic [GAIN_BITS-1:0]          gain_sel;
    logic signed [SAMPLE_BITS-1:0] hist_operand;
    logic signed [SCALED_BITS-1:0] rounded;
    logic signed [SHIFTED_BITS-1:0] shifted;
    logic signed [SAMPLE_BITS-1:0] sat_sample;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign last_pass = (func_reg != FUNC_INTERP) || (step_reg == STEP_W'(FACTOR - 1));
    assign gain_sel = (func_reg == FUNC_INTERP) ? up_gain_reg : down_gain_reg;

    assign m_valid       = m_valid_reg;
    assign m_out_sample  = out_sample_reg;
    assign m_last_of_run = last_reg;

    // Drop unwritten slots to zero
    assign hist_operand = rvld_reg ? rdata_reg : '0;

    // Round half up to Q1.15 and clamp
    assign rounded = scaled_reg + ROUND_HALF;
    assign shifted = rounded[SCALED_BITS-1:ROUND_SHIFT];
    always_comb begin
        if (shifted > SAT_MAX) begin
            sat_sample = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (shifted < SAT_MIN) begin
            sat_sample = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            sat_sample = shifted[SAMPLE_BITS-1:0];
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire && (s_func == FUNC_INTERP || s_func == FUNC_DECIM)) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                if (func_reg == FUNC_DECIM && phase_reg != '0) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_MAC;
                end
            end
            S_MAC: begin
                if (k_reg == ADDR_W'(TAPS - 1)) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!st1_v_reg && !st2_v_reg) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = last_pass ? S_IDLE : S_WRITE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and sequencer outputs
    always_comb begin
        func_next       = func_reg;
        sample_next     = sample_reg;
        step_next       = step_reg;
        wp_next         = wp_reg;
        phase_next      = phase_reg;
        vld_next        = vld_reg;
        rd_addr_next    = rd_addr_reg;
        k_next          = k_reg;
        tap_q_next      = tap_coef(k_reg);
        st1_v_next      = 1'b0;
        st2_v_next      = st1_v_reg;
        prod_next       = tap_q_reg * hist_operand;
        acc_next        = st2_v_reg ? acc_reg + ACC_BITS'(prod_reg) : acc_reg;
        scaled_next     = scaled_reg;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;
        out_sample_next = out_sample_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        mem_wdata       = sample_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    func_next   = s_func;
                    sample_next = s_in_sample;
                    step_next   = '0;
                    if (s_func == FUNC_CLEAR) begin
                        vld_next   = '0;
                        wp_next    = '0;
                        phase_next = '0;
                    end
                end
            end
            S_WRITE: begin
                // Push the new sample, or a stuffed zero after the first pass
                mem_we = 1'b1;
                if (func_reg == FUNC_INTERP && step_reg != '0) begin
                    mem_wdata = '0;
                end
                vld_next[wp_reg] = 1'b1;
                wp_next      = (wp_reg == ADDR_W'(TAPS - 1)) ? '0 : wp_reg + 1'b1;
                rd_addr_next = wp_reg;
                k_next       = '0;
                acc_next     = '0;
                if (func_reg == FUNC_DECIM) begin
                    phase_next = (phase_reg == STEP_W'(FACTOR - 1)) ? '0 : phase_reg + 1'b1;
                end
            end
            S_MAC: begin
                // Walk back from the newest sample, one tap a cycle
                st1_v_next   = 1'b1;
                rd_addr_next = (rd_addr_reg == '0) ? ADDR_W'(TAPS - 1) : rd_addr_reg - 1'b1;
                if (k_reg != ADDR_W'(TAPS - 1)) begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!st1_v_reg && !st2_v_reg) begin
                    scaled_next = acc_reg * $signed({1'b0, gain_sel});
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_sample_next = sat_sample;
                    last_next       = last_pass;
                    if (!last_pass) begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Gain registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_gain_reg   <= UP_GAIN_RESET;
            down_gain_reg <= DOWN_GAIN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_UP_GAIN:   up_gain_reg   <= cfg_wdata;
                REG_DOWN_GAIN: down_gain_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // History memory, one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[wp_reg] <= mem_wdata;
        end
        rdata_reg <= hist_mem[rd_addr_reg];
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wp_reg      <= '0;
            phase_reg   <= '0;
            vld_reg     <= '0;
            st1_v_reg   <= 1'b0;
            st2_v_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
            func_reg    <= FUNC_CLEAR;
            k_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            phase_reg   <= phase_next;
            vld_reg     <= vld_next;
            st1_v_reg   <= st1_v_next;
            st2_v_reg   <= st2_v_next;
            m_valid_reg <= m_valid_next;
            step_reg    <= step_next;
            func_reg    <= func_next;
            k_reg       <= k_next;
        end
    end

    // Payload and pipeline data
    always_ff @(posedge aclk) begin
        sample_reg     <= sample_next;
        rd_addr_reg    <= rd_addr_next;
        rvld_reg       <= vld_reg[rd_addr_reg];
        tap_q_reg      <= tap_q_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        scaled_reg     <= scaled_next;
        out_sample_reg <= out_sample_next;
        last_reg       <= last_next;
    end

`ifndef SYNTH
    // Product stage only fires in the cycle after a valid memory read
    a_mac_order: assert property (@(posedge aclk) disable iff (!aresetn)
        st2_v_reg |-> $past(st1_v_reg))
        else $error("MAC product without a preceding read");

    // Write pointer stays inside the delay line
    a_wp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= ADDR_W'(TAPS - 1))
        else $error("write pointer out of range");

    // Phase and pass counters stay inside the group
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= STEP_W'(FACTOR - 1) && step_reg <= STEP_W'(FACTOR - 1))
        else $error("phase or pass counter out of range");

    // A result is only loaded once the pipeline has fully drained
    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> (!st1_v_reg && !st2_v_reg))
        else $error("result taken before accumulation finished");
`endif

endmodule
